>>> hw/rtl/sfsd_pkg.sv
// ----------------------------------------------------------------------------
// Sensor frame sync deframer package
// Constants, payload types and the stage-to-stage request types shared by
// the deframer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package sfsd_pkg;

    // Frame geometry: marker, id, eight body bytes, checksum.
    localparam int unsigned FRAME_LEN = 11;
    localparam int unsigned WIN_DEPTH = FRAME_LEN - 1;
    localparam int unsigned FILL_W    = 4;
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned BODY_LEN  = 8;
    localparam int unsigned ID_W      = 7;

    // Stream data widths, rounded up to whole bytes.
    localparam int unsigned S_TDATA_W = 8;
    localparam int unsigned M_FIELD_W = ID_W + BODY_LEN * BYTE_W;
    localparam int unsigned M_TDATA_W = ((M_FIELD_W + 7) / 8) * 8;
    localparam int unsigned M_PAD_W   = M_TDATA_W - M_FIELD_W;

    // Marker and accepted id range.
    localparam logic [BYTE_W-1:0] FRAME_MARKER = 8'h55;
    localparam logic [BYTE_W-1:0] ID_LOW       = 8'h50;
    localparam logic [BYTE_W-1:0] ID_HIGH      = 8'h53;

    typedef logic [BYTE_W-1:0] octet_t;

    // One received byte handed to the window stage.
    typedef struct packed {
        logic   valid;
        octet_t data;
    } byte_req_t;

    // Frame result from the window stage; body[0] sits in the lowest bits.
    typedef struct packed {
        logic                       hit;
        logic [ID_W-1:0]            frame_id;
        octet_t [BODY_LEN-1:0]      body;
    } frame_res_t;

endpackage

`default_nettype wire

>>> hw/rtl/sfsd_window.sv
// ----------------------------------------------------------------------------
// Sensor frame sync deframer: window stage
// Holds the sliding byte window and its fill count, checks marker and sum
// when the window is full, and either consumes the frame or drops the
// oldest byte.
// ----------------------------------------------------------------------------
`default_nettype none

module sfsd_window (
    input  wire                     aclk,
    input  wire                     aresetn,
    input  wire sfsd_pkg::byte_req_t step,
    output sfsd_pkg::frame_res_t    res
);
    import sfsd_pkg::*;

    octet_t              win_reg  [WIN_DEPTH];
    octet_t              win_next [WIN_DEPTH];
    logic [FILL_W-1:0]   fill_reg;
    logic [FILL_W-1:0]   fill_next;

    octet_t              sum;
    logic                full;
    logic                marker_ok;
    logic                frame_ok;
    logic                id_ok;

    // Checksum over the ten stored bytes and the frame checks.
    always_comb begin
        sum = '0;
        for (int k = 0; k < WIN_DEPTH; k++) begin
            sum = sum + win_reg[k];
        end
        full      = (fill_reg >= FILL_W'(WIN_DEPTH));
        marker_ok = (win_reg[0] == FRAME_MARKER);
        frame_ok  = full && marker_ok && (sum == step.data);
        id_ok     = (win_reg[1] >= ID_LOW) && (win_reg[1] <= ID_HIGH);
    end

    // Result fields come straight from the stored window.
    always_comb begin
        res.hit      = step.valid && frame_ok && id_ok;
        res.frame_id = win_reg[1][ID_W-1:0];
        for (int k = 0; k < BODY_LEN; k++) begin
            res.body[k] = win_reg[k + 2];
        end
    end

    // Store, consume or slide the window by one byte.
    always_comb begin
        win_next  = win_reg;
        fill_next = fill_reg;
        if (step.valid) begin
            if (!full) begin
                win_next[fill_reg] = step.data;
                fill_next          = fill_reg + 1'b1;
            end else if (frame_ok) begin
                fill_next = '0;
            end else begin
                for (int k = 0; k < WIN_DEPTH - 1; k++) begin
                    win_next[k] = win_reg[k + 1];
                end
                win_next[WIN_DEPTH-1] = step.data;
                fill_next             = FILL_W'(WIN_DEPTH);
            end
        end
    end

    // Window bytes carry no reset; entries are written before they are read.
    always_ff @(posedge aclk) begin
        win_reg <= win_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
        end else begin
            fill_reg <= fill_next;
        end
    end

    // The fill count never passes the stored depth.
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FILL_W'(WIN_DEPTH))
        else $error("window fill count out of range");

    // A byte into a partial window grows the count by one.
    a_fill_grow: assert property (@(posedge aclk) disable iff (!aresetn)
        (step.valid && !full) |=> (fill_reg == $past(fill_reg) + 1'b1))
        else $error("window fill count did not advance");

    // An emitted frame always empties the window.
    a_hit_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        res.hit |=> (fill_reg == '0))
        else $error("window not cleared after a frame");

endmodule

`default_nettype wire

>>> hw/rtl/sfsd_out_reg.sv
// ----------------------------------------------------------------------------
// Sensor frame sync deframer: result register
// Holds one finished frame on the master stream until it is taken and
// reports whether a new result can be loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module sfsd_out_reg (
    input  wire                                   aclk,
    input  wire                                   aresetn,
    input  wire                                   load,
    input  wire sfsd_pkg::frame_res_t             load_res,
    output logic                                  space,
    output logic                                  m_tvalid,
    input  wire                                   m_tready,
    // Fields from bit 0: frame_id[6:0], body_byte_0..7 (8 bits each), zero pad.
    output logic [sfsd_pkg::M_TDATA_W-1:0]        m_tdata
);
    import sfsd_pkg::*;

    logic                   valid_reg;
    logic                   valid_next;
    logic [M_TDATA_W-1:0]   data_reg;

    // Room for a result when empty or when the held one leaves this cycle.
    assign space = !valid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg;
        if (valid_reg && m_tready) begin
            valid_next = 1'b0;
        end
        if (load && load_res.hit) begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Payload capture packs id first, then body bytes in order.
    always_ff @(posedge aclk) begin
        if (load && load_res.hit) begin
            data_reg <= {{M_PAD_W{1'b0}}, load_res.body, load_res.frame_id};
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;

endmodule

`default_nettype wire

>>> hw/rtl/sensor_frame_sync_deframer.sv
// ----------------------------------------------------------------------------
// Sensor frame sync deframer
// Finds 11-byte frames (marker 0x55, id, eight body bytes, 8-bit sum) in a
// received byte stream and emits id and body of frames with id 0x50..0x53.
//
// Usage:
//   The slave stream carries one received byte per request in s_tdata. The
//   master stream carries one result per emitted frame; most bytes produce
//   none. A byte is taken into an input register; once the output register has
//   room it joins the 10-byte window, the marker and sum are checked and any
//   result is loaded into the output register, which drives m_tvalid.
//   Throughput: one byte per cycle while the output register has room, set by
//   the single window/check stage.
//   Stall: while a result waits with m_tready low, the input register keeps
//   its byte, whether or not that byte would make a result; s_tready drops
//   once the input register is occupied as well.
//   Reset: aresetn low for one cycle empties the window, the input register
//   and the output register; no flush pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module sensor_frame_sync_deframer (
    input  wire                                   aclk,
    input  wire                                   aresetn,
    input  wire                                   s_tvalid,
    output logic                                  s_tready,
    // Fields from bit 0: rx_byte[7:0].
    input  wire  [sfsd_pkg::S_TDATA_W-1:0]        s_tdata,
    output logic                                  m_tvalid,
    input  wire                                   m_tready,
    // Fields from bit 0: frame_id[6:0], body_byte_0..7 (8 bits each), zero pad.
    output logic [sfsd_pkg::M_TDATA_W-1:0]        m_tdata
);
    import sfsd_pkg::*;

    logic           in_valid_reg;
    logic           in_valid_next;
    octet_t         in_data_reg;
    logic           s_accept;
    logic           proc_go;
    logic           out_space;
    byte_req_t      step;
    frame_res_t     res;

    // A held byte moves on whenever the output register has room.
    assign proc_go  = in_valid_reg && out_space;
    assign s_tready = !in_valid_reg || proc_go;
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (proc_go) begin
            in_valid_next = 1'b0;
        end
        if (s_accept) begin
            in_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    // Input byte register.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_data_reg <= s_tdata[BYTE_W-1:0];
        end
    end

    always_comb begin
        step.valid = proc_go;
        step.data  = in_data_reg;
    end

    sfsd_window u_window (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .res     (res)
    );

    sfsd_out_reg u_out_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (proc_go),
        .load_res (res),
        .space    (out_space),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire

>>> dv/tb_sensor_frame_sync_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sensor frame sync deframer testbench
// Streams received bytes into the deframer, tracks the 11-byte window in a
// scoreboard of its own and checks every emitted id and body field in order.
// Traffic is mostly well-formed frames mixed with corrupt frames and noise,
// under phases of sender gaps, receiver stalls and one long receiver hold-off.
// ----------------------------------------------------------------------------

// Scoreboard: follows the deframer window and holds the frames still owed.
class frame_scoreboard;

    typedef struct packed {
        logic [sfsd_pkg::ID_W-1:0]                frame_id;
        sfsd_pkg::octet_t [sfsd_pkg::BODY_LEN-1:0] body;
    } frame_fields_t;

    sfsd_pkg::octet_t window [sfsd_pkg::FRAME_LEN];
    int unsigned      fill;
    frame_fields_t    owed_frames [$];
    int unsigned      frames_owed_total;
    int unsigned      errors;

    function new();
        fill              = 0;
        frames_owed_total = 0;
        errors            = 0;
        foreach (window[k]) window[k] = '0;
    endfunction

    function void flag_error(string what, logic [71:0] exp_val, logic [71:0] act_val);
        if (errors < 10) begin
            $display("ERROR: %s expected 0x%0h got 0x%0h", what, exp_val, act_val);
        end
        errors++;
    endfunction

    // Add one accepted byte to the window and work out whether a frame is owed.
    function void note_byte(sfsd_pkg::octet_t rx_byte);
        sfsd_pkg::octet_t sum;
        frame_fields_t    frame;
        if (fill > sfsd_pkg::WIN_DEPTH) fill = sfsd_pkg::WIN_DEPTH;
        window[fill] = rx_byte;
        fill++;
        if (fill < sfsd_pkg::FRAME_LEN) return;

        sum = '0;
        for (int k = 0; k < sfsd_pkg::WIN_DEPTH; k++) sum += window[k];

        // Bad marker or sum: drop the oldest byte and slide by one.
        if (window[0] != sfsd_pkg::FRAME_MARKER || sum != window[sfsd_pkg::WIN_DEPTH]) begin
            for (int k = 0; k < sfsd_pkg::WIN_DEPTH; k++) window[k] = window[k+1];
            fill = sfsd_pkg::WIN_DEPTH;
            return;
        end

        // Good frame: consumed either way, emitted only for ids in range.
        fill = 0;
        if (window[1] >= sfsd_pkg::ID_LOW && window[1] <= sfsd_pkg::ID_HIGH) begin
            frame.frame_id = window[1][sfsd_pkg::ID_W-1:0];
            for (int k = 0; k < sfsd_pkg::BODY_LEN; k++) frame.body[k] = window[2+k];
            owed_frames.push_back(frame);
            frames_owed_total++;
        end
    endfunction

    // Compare one accepted result with the oldest owed frame.
    function void check_result(logic [sfsd_pkg::M_TDATA_W-1:0] data);
        frame_fields_t exp_frame;
        if (owed_frames.size() == 0) begin
            flag_error("result with no frame owed, tdata", '0, data);
            return;
        end
        exp_frame = owed_frames.pop_front();
        if (data[sfsd_pkg::ID_W-1:0] !== exp_frame.frame_id) begin
            flag_error("frame_id", exp_frame.frame_id, data[sfsd_pkg::ID_W-1:0]);
        end
        for (int k = 0; k < sfsd_pkg::BODY_LEN; k++) begin
            if (data[sfsd_pkg::ID_W + 8*k +: 8] !== exp_frame.body[k]) begin
                flag_error($sformatf("body_byte_%0d", k), exp_frame.body[k],
                           data[sfsd_pkg::ID_W + 8*k +: 8]);
            end
        end
    endfunction

endclass

module tb_sensor_frame_sync_deframer;

    import sfsd_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned PHASE_BYTES  = 150;
    localparam int unsigned MIN_FRAMES   = 40;
    localparam int unsigned DRAIN_CYCLES = 10;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;

    frame_scoreboard deframe_sb;
    int unsigned     send_idle_pct;
    int unsigned     recv_stall_pct;
    logic            hold_go;
    int unsigned     cycle_count;

    sensor_frame_sync_deframer u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // 2 ns clock.
    initial aclk = 1'b0;
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Offer one byte, with random gaps before it, and wait for its request
    // to be taken.
    task automatic send_byte(input octet_t rx_byte);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= rx_byte;
        do @(posedge aclk); while (!s_tready);
        deframe_sb.note_byte(rx_byte);
    endtask

    // Marker, id, body and sum; a nonzero sum_err spoils it, and bad_marker sends a random marker.
    task automatic send_frame(input octet_t id, input octet_t [BODY_LEN-1:0] body,
                              input octet_t sum_err, input bit bad_marker);
        octet_t marker;
        octet_t sum;
        marker = bad_marker ? octet_t'($urandom_range(255)) : FRAME_MARKER;
        sum    = marker + id;
        for (int k = 0; k < BODY_LEN; k++) sum += body[k];
        send_byte(marker);
        send_byte(id);
        for (int k = 0; k < BODY_LEN; k++) send_byte(body[k]);
        send_byte(sum + sum_err);
    endtask

    // One random chunk of traffic: mostly good frames, some corrupt, some noise.
    task automatic send_random_chunk();
        octet_t [BODY_LEN-1:0] body;
        int unsigned           pick;
        pick = $urandom_range(99);
        for (int k = 0; k < BODY_LEN; k++) body[k] = octet_t'($urandom_range(255));
        if (pick < 60) begin
            send_frame(ID_LOW + octet_t'($urandom_range(3)), body, '0, 1'b0);
        end else if (pick < 70) begin
            send_frame(octet_t'($urandom_range(255)), body, '0, 1'b0);
        end else if (pick < 78) begin
            send_frame(ID_LOW + octet_t'($urandom_range(3)), body,
                       octet_t'($urandom_range(1, 255)), 1'b0);
        end else if (pick < 84) begin
            send_frame(ID_LOW + octet_t'($urandom_range(3)), body, '0, 1'b1);
        end else begin
            // Noise, often with a stray marker to tempt a false lock.
            repeat ($urandom_range(1, 4)) begin
                send_byte($urandom_range(1) ? FRAME_MARKER : octet_t'($urandom_range(255)));
            end
        end
    endtask

    // Result side: random stalls, one long hold-off on request, and checking.
    initial begin
        int unsigned hold_left;
        bit          hold_used;
        hold_left = 0;
        hold_used = 1'b0;
        m_tready  = 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid === 1'b1 && m_tready) deframe_sb.check_result(m_tdata);
            if (hold_go && !hold_used) begin
                hold_left = HOLD_CYCLES;
                hold_used = 1'b1;
            end
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Watchdog.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("sensor_frame_sync_deframer: mismatch");
        $finish;
    end

    // Main sequence.
    initial begin
        octet_t [BODY_LEN-1:0] body;
        int unsigned           sent_mark;
        int unsigned           phase_start;

        deframe_sb     = new();
        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        hold_go        = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        sent_mark      = 0;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: extreme body values, an in-range id, an out-of-range id
        // whose low seven bits would alias an accepted id, then loose bytes.
        body = {8'hAA, 8'h55, 8'hFE, 8'h7F, 8'h80, 8'h01, 8'hFF, 8'h00};
        send_frame(ID_LOW, body, '0, 1'b0);
        body = {8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
        send_frame(8'hD3, body, '0, 1'b0);
        send_byte(8'hFF);
        send_byte(FRAME_MARKER);
        send_byte(8'h00);

        // Random traffic over four flow-control phases.
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 63; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 63; end
                default: begin send_idle_pct = 29; recv_stall_pct = 29; end
            endcase
            phase_start = sent_mark;
            while (sent_mark - phase_start < PHASE_BYTES ||
                   (phase == 3 && deframe_sb.frames_owed_total < MIN_FRAMES)) begin
                // Long receiver hold-off early in the unthrottled phase.
                if (phase == 0 && sent_mark - phase_start >= 30) hold_go <= 1'b1;
                send_random_chunk();
                sent_mark = sent_mark + 11;
            end
        end

        s_tvalid <= 1'b0;
        while (deframe_sb.owed_frames.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (deframe_sb.owed_frames.size() != 0) begin
            deframe_sb.flag_error("frames never emitted, count", '0,
                                  deframe_sb.owed_frames.size());
        end
        if (deframe_sb.errors == 0) begin
            $display("sensor_frame_sync_deframer: match");
        end else begin
            $display("sensor_frame_sync_deframer: mismatch");
        end
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/sfsd_pkg.sv
hw/rtl/sfsd_window.sv
hw/rtl/sfsd_out_reg.sv
hw/rtl/sensor_frame_sync_deframer.sv
dv/tb_sensor_frame_sync_deframer.sv
